// ----- rtl/core/dsl_pkg.sv -----
package dsl_pkg;

  // default sizes
  localparam int IN_MAX_DEF    = 64;
  localparam int OUT_MAX_DEF   = 32;
  localparam int SIG_DEPTH_DEF = 1024;
  localparam int FRAC_BITS_DEF = 16;

  // register reset values
  localparam logic [16:0] LEARN_RATE_RST = 17'd6554;
  localparam logic [6:0]  IN_COUNT_RST   = 7'd64;
  localparam logic [5:0]  OUT_COUNT_RST  = 6'd32;

  // register indexes
  localparam logic [1:0] REG_LEARN_RATE = 2'd0;
  localparam logic [1:0] REG_IN_COUNT   = 2'd1;
  localparam logic [1:0] REG_OUT_COUNT  = 2'd2;

  // command codes
  localparam logic [2:0] CMD_WRITE  = 3'd0;
  localparam logic [2:0] CMD_INPUT  = 3'd1;
  localparam logic [2:0] CMD_TARGET = 3'd2;
  localparam logic [2:0] CMD_HIDDEN = 3'd3;
  localparam logic [2:0] CMD_UPDATE = 3'd4;
  localparam logic [2:0] CMD_READ   = 3'd5;

  // result kinds
  localparam logic [1:0] KIND_ACT    = 2'd0;
  localparam logic [1:0] KIND_ERR    = 2'd1;
  localparam logic [1:0] KIND_WEIGHT = 2'd2;
  localparam logic [1:0] KIND_DONE   = 2'd3;

  // e^-1 in Q32
  localparam logic [63:0] E_INV_Q32 = 64'd1580030169;

  typedef enum logic [4:0] {
    S_IDLE, S_WW, S_IB,
    S_FRD, S_FMUL, S_FACC, S_FSAT, S_FIDX, S_FTAB, S_FOUT,
    S_ERD, S_EDER, S_ESAT, S_EMUL, S_EOUT,
    S_HMUL, S_HACC,
    S_URD, S_ULE, S_ULE2, S_UWRD, S_UMUL, S_UWR, S_UDONE,
    S_RRD, S_ROUT
  } state_t;

  // saturate a wide signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    if (v > $signed(68'h0_0000_0000_7FFF_FFFF)) return 32'sh7FFF_FFFF;
    if (v < $signed(68'hF_FFFF_FFFF_8000_0000)) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // shift-subtract divide, used only while building the sigmoid table
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [64:0] rem;
    logic [63:0] q;
    rem = '0;
    q   = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], n[b]};
      if (rem >= {1'b0, d}) begin
        rem  = rem - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // sigmoid at the slot midpoint, integer series for e^-|x|
  function automatic logic [31:0] sig_entry(input int unsigned i, input int unsigned depth,
                                            input int unsigned frac);
    logic [63:0] off, eight, mag, n, f, term, e, den, s, one;
    longint sm;
    logic neg;
    off   = udiv64((64'(2 * i + 1) * 64'd8) << 32, 64'(depth));
    eight = 64'd8 << 32;
    neg   = off < eight;
    mag   = neg ? eight - off : off - eight;
    n     = mag >> 32;
    f     = mag & 64'hFFFF_FFFF;
    term  = 64'd1 << 32;
    sm    = longint'(term);
    for (int k = 1; k <= 14; k++) begin
      term = udiv64((term * f) >> 32, 64'(k));
      if (k % 2 == 1) sm = sm - longint'(term);
      else sm = sm + longint'(term);
    end
    e = (sm < 0) ? 64'd0 : 64'(sm);
    for (int k = 0; k < n; k++) e = (e * E_INV_Q32) >> 32;
    den = (64'd1 << 32) + e;
    one = 64'd1 << frac;
    s   = udiv64((64'd1 << (32 + frac)) + (den >> 1), den);
    return neg ? 32'(one - s) : 32'(s);
  endfunction

endpackage

// ----- rtl/core/dsl_ram.sv -----
module dsl_ram
  import dsl_pkg::*;
#(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, registered read
  always_ff @(posedge clk) begin
    if (we) mem_r[waddr] <= wdata;
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/dense_sigmoid_layer_backprop.sv -----
// channel | ports                                        | beat taken when
// in      | start busy in_cmd in_row in_col in_value ... | start & !busy
// out     | out_valid out_kind out_index out_result_...  | out_valid (one cycle)
// cfg     | cfg_valid cfg_ready cfg_index cfg_data       | cfg_valid & cfg_ready
// One 33x33 multiplier is shared by the forward pass and the error, hidden and
// update commands under a sequencer; busy is high until a command finishes.
// Forward pass: each multiply-accumulate reads, multiplies and accumulates; each
// neuron then saturates, indexes the sigmoid table and outputs. Update: each
// weight is read, multiplied and written back. Reset is synchronous; the weight
// and buffer memories hold garbage until written. Results cannot stall.
module dense_sigmoid_layer_backprop
  import dsl_pkg::*;
#(
  parameter int IN_MAX          = IN_MAX_DEF,
  parameter int OUT_MAX         = OUT_MAX_DEF,
  parameter int SIG_TABLE_DEPTH = SIG_DEPTH_DEF,
  parameter int FRAC_BITS       = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_cmd,
  input  logic [6:0]         in_row,
  input  logic [4:0]         in_col,
  input  logic signed [31:0] in_value,
  input  logic signed [31:0] in_aux_value,
  input  logic               in_last,
  output logic               out_valid,
  output logic [1:0]         out_kind,
  output logic [6:0]         out_index,
  output logic signed [31:0] out_result_value,
  output logic               out_run_end,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int NI_W  = $clog2(IN_MAX + 1);
  localparam int NO_W  = $clog2(OUT_MAX + 1);
  localparam int IBW   = (IN_MAX > 1) ? $clog2(IN_MAX) : 1;
  localparam int OAW   = (OUT_MAX > 1) ? $clog2(OUT_MAX) : 1;
  localparam int WDEP  = (IN_MAX + 1) * OUT_MAX;
  localparam int WAW   = $clog2(WDEP);
  localparam int TW    = $clog2(SIG_TABLE_DEPTH);
  localparam logic signed [32:0] ONE = 33'sd1 <<< FRAC_BITS;

  typedef logic [31:0] sig_tab_t [SIG_TABLE_DEPTH];

  function automatic sig_tab_t build_sig_tab();
    sig_tab_t tb;
    for (int k = 0; k < SIG_TABLE_DEPTH; k++) tb[k] = sig_entry(k, SIG_TABLE_DEPTH, FRAC_BITS);
    return tb;
  endfunction

  localparam sig_tab_t SIG_TAB = build_sig_tab();

  function automatic logic [WAW-1:0] waddr_of(input logic [31:0] r, input logic [31:0] c);
    return WAW'(r * 32'(OUT_MAX) + c);
  endfunction

  state_t state_r, state_nxt;
  logic [2:0]         cmd_r, cmd_nxt;
  logic [6:0]         row_r, row_nxt;
  logic [4:0]         col_r, col_nxt;
  logic signed [31:0] val_r, val_nxt, aux_r, aux_nxt;
  logic               last_r, last_nxt;
  logic [NI_W-1:0]    i_r, i_nxt;
  logic [NO_W-1:0]    j_r, j_nxt;
  logic signed [63:0] acc_r, acc_nxt;
  logic signed [65:0] p_r, p_nxt;
  logic signed [31:0] x_r, x_nxt, eop_r, eop_nxt, d_r, d_nxt, le_r, le_nxt, wq_r, wq_nxt;
  logic [TW-1:0]      idx_r, idx_nxt;
  logic [31:0]        sig_r;
  logic signed [47:0] hacc_r, hacc_nxt;
  logic               out_valid_r, out_valid_nxt, out_end_r, out_end_nxt;
  logic [1:0]         out_kind_r, out_kind_nxt;
  logic [6:0]         out_index_r, out_index_nxt;
  logic signed [31:0] out_value_r, out_value_nxt;
  logic [16:0]        lr_r;
  logic [6:0]         inc_r;
  logic [5:0]         outc_r;

  logic [NI_W-1:0]    ni;
  logic [NO_W-1:0]    no;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;
  logic signed [31:0] q_sat;
  logic signed [47:0] t_s, t_sh;
  logic signed [48:0] hsum;
  logic signed [47:0] hsat;
  logic               row_ok_w, row_lt_no;

  logic           w_we, ib_we, act_we, err_we;
  logic [WAW-1:0] w_waddr, w_raddr;
  logic [IBW-1:0] ib_waddr, ib_raddr;
  logic [OAW-1:0] act_waddr, act_raddr, err_waddr, err_raddr;
  logic [31:0]    w_wdata, ib_wdata, act_wdata, err_wdata;
  logic [31:0]    w_rdata, ib_rdata, act_rdata, err_rdata;

  dsl_ram #(.WIDTH(32), .DEPTH(WDEP)) u_weights (
    .clk, .we(w_we), .waddr(w_waddr), .wdata(w_wdata), .raddr(w_raddr), .rdata(w_rdata));
  dsl_ram #(.WIDTH(32), .DEPTH(IN_MAX)) u_inbuf (
    .clk, .we(ib_we), .waddr(ib_waddr), .wdata(ib_wdata), .raddr(ib_raddr), .rdata(ib_rdata));
  dsl_ram #(.WIDTH(32), .DEPTH(OUT_MAX)) u_act (
    .clk, .we(act_we), .waddr(act_waddr), .wdata(act_wdata), .raddr(act_raddr),
    .rdata(act_rdata));
  dsl_ram #(.WIDTH(32), .DEPTH(OUT_MAX)) u_err (
    .clk, .we(err_we), .waddr(err_waddr), .wdata(err_wdata), .raddr(err_raddr),
    .rdata(err_rdata));

  // clamped counts
  assign ni = (32'(inc_r) < IN_MAX) ? NI_W'(inc_r) : NI_W'(IN_MAX);
  assign no = (32'(outc_r) < OUT_MAX) ? NO_W'(outc_r) : NO_W'(OUT_MAX);

  // shared multiplier and its rescale
  assign prod  = mul_a * mul_b;
  assign q_sat = sat32(68'(p_r >>> FRAC_BITS));

  // table index from the saturated sum
  assign t_s  = (48'(x_r) + (48'sd8 <<< FRAC_BITS)) * $signed(48'(SIG_TABLE_DEPTH));
  assign t_sh = t_s >>> (FRAC_BITS + 4);

  // hidden accumulator add with 48-bit saturation
  assign hsum = 49'(hacc_r) + 49'(q_sat);
  assign hsat = (hsum > $signed({2'b00, {47{1'b1}}})) ? {1'b0, {47{1'b1}}} :
                (hsum < $signed({2'b11, {47{1'b0}}})) ? {1'b1, {47{1'b0}}} : hsum[47:0];

  assign row_ok_w  = (32'(row_r) <= IN_MAX) && (32'(col_r) < OUT_MAX);
  assign row_lt_no = 32'(row_r) < 32'(no);

  // sigmoid table lookup, registered
  always_ff @(posedge clk) sig_r <= SIG_TAB[idx_r];

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cmd_nxt = cmd_r; row_nxt = row_r; col_nxt = col_r;
    val_nxt = val_r; aux_nxt = aux_r; last_nxt = last_r;
    i_nxt = i_r; j_nxt = j_r; acc_nxt = acc_r; p_nxt = p_r;
    x_nxt = x_r; eop_nxt = eop_r; d_nxt = d_r; le_nxt = le_r; wq_nxt = wq_r;
    idx_nxt = idx_r; hacc_nxt = hacc_r;
    out_valid_nxt = 1'b0; out_kind_nxt = out_kind_r; out_index_nxt = out_index_r;
    out_value_nxt = out_value_r; out_end_nxt = out_end_r;
    mul_a = '0; mul_b = '0;
    w_we = 1'b0; w_waddr = '0; w_wdata = 32'(val_r); w_raddr = '0;
    ib_we = 1'b0; ib_waddr = IBW'(row_r); ib_wdata = 32'(val_r); ib_raddr = '0;
    act_we = 1'b0; act_waddr = OAW'(j_r); act_wdata = sig_r; act_raddr = OAW'(row_r);
    err_we = 1'b0; err_waddr = OAW'(row_r); err_wdata = 32'(q_sat); err_raddr = OAW'(j_r);
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt = in_cmd; row_nxt = in_row; col_nxt = in_col;
          val_nxt = in_value; aux_nxt = in_aux_value; last_nxt = in_last;
          case (in_cmd)
            CMD_WRITE:  state_nxt = S_WW;
            CMD_INPUT:  state_nxt = S_IB;
            CMD_TARGET: state_nxt = S_ERD;
            CMD_HIDDEN: state_nxt = S_HMUL;
            CMD_UPDATE: state_nxt = S_URD;
            CMD_READ:   state_nxt = S_RRD;
            default:    state_nxt = S_IDLE;
          endcase
          i_nxt = '0;
          j_nxt = '0;
        end
      end
      // weight write
      S_WW: begin
        w_we      = row_ok_w;
        w_waddr   = waddr_of(32'(row_r), 32'(col_r));
        state_nxt = S_IDLE;
      end
      // input element, forward pass on last
      S_IB: begin
        ib_we = 32'(row_r) < IN_MAX;
        i_nxt = '0; j_nxt = '0; acc_nxt = '0;
        state_nxt = (last_r && no != '0) ? S_FRD : S_IDLE;
      end
      S_FRD: begin
        w_raddr   = waddr_of(32'(i_r), 32'(j_r));
        ib_raddr  = (32'(i_r) < IN_MAX) ? IBW'(i_r) : '0;
        state_nxt = S_FMUL;
      end
      S_FMUL: begin
        mul_a     = (i_r == ni) ? ONE : 33'($signed(ib_rdata));
        mul_b     = 33'($signed(w_rdata));
        p_nxt     = prod;
        state_nxt = S_FACC;
      end
      S_FACC: begin
        acc_nxt = acc_r + 64'(p_r >>> FRAC_BITS);
        if (i_r == ni) state_nxt = S_FSAT;
        else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = S_FRD;
        end
      end
      S_FSAT: begin
        x_nxt     = sat32(68'(acc_r));
        state_nxt = S_FIDX;
      end
      S_FIDX: begin
        if (t_s < 0) idx_nxt = '0;
        else if (t_sh >= $signed(48'(SIG_TABLE_DEPTH))) idx_nxt = TW'(SIG_TABLE_DEPTH - 1);
        else idx_nxt = TW'(t_sh);
        state_nxt = S_FTAB;
      end
      S_FTAB: state_nxt = S_FOUT;
      S_FOUT: begin
        act_we        = 1'b1;
        out_valid_nxt = 1'b1;
        out_kind_nxt  = KIND_ACT;
        out_index_nxt = 7'(j_r);
        out_value_nxt = $signed(sig_r);
        out_end_nxt   = (j_r + 1'b1) == no;
        i_nxt = '0; acc_nxt = '0;
        if ((j_r + 1'b1) == no) state_nxt = S_IDLE;
        else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = S_FRD;
        end
      end
      // error term: activation derivative times error operand
      S_ERD: state_nxt = (cmd_r == CMD_HIDDEN || row_lt_no) ? S_EDER : S_IDLE;
      S_EDER: begin
        mul_a = 33'($signed(act_rdata));
        mul_b = ONE - 33'($signed(act_rdata));
        p_nxt = prod;
        if (cmd_r == CMD_TARGET) eop_nxt = sat32(68'(val_r) - 68'($signed(act_rdata)));
        state_nxt = S_ESAT;
      end
      S_ESAT: begin
        d_nxt     = q_sat;
        state_nxt = S_EMUL;
      end
      S_EMUL: begin
        mul_a     = 33'(eop_r);
        mul_b     = 33'(d_r);
        p_nxt     = prod;
        state_nxt = S_EOUT;
      end
      S_EOUT: begin
        err_we        = 1'b1;
        out_valid_nxt = 1'b1;
        out_kind_nxt  = KIND_ERR;
        out_index_nxt = row_r;
        out_value_nxt = q_sat;
        out_end_nxt   = 1'b1;
        state_nxt     = S_IDLE;
      end
      // hidden term accumulate
      S_HMUL: begin
        mul_a     = 33'(val_r);
        mul_b     = 33'(aux_r);
        p_nxt     = prod;
        state_nxt = S_HACC;
      end
      S_HACC: begin
        hacc_nxt  = hsat;
        state_nxt = S_IDLE;
        if (last_r) begin
          hacc_nxt = '0;
          eop_nxt  = sat32(68'(hsat));
          if (row_lt_no) state_nxt = S_ERD;
        end
      end
      // weight update
      S_URD: state_nxt = (no == '0) ? S_UDONE : S_ULE;
      S_ULE: begin
        mul_a     = $signed({16'b0, lr_r});
        mul_b     = 33'($signed(err_rdata));
        p_nxt     = prod;
        state_nxt = S_ULE2;
      end
      S_ULE2: begin
        le_nxt    = q_sat;
        i_nxt     = '0;
        state_nxt = S_UWRD;
      end
      S_UWRD: begin
        w_raddr   = waddr_of(32'(i_r), 32'(j_r));
        ib_raddr  = (32'(i_r) < IN_MAX) ? IBW'(i_r) : '0;
        state_nxt = S_UMUL;
      end
      S_UMUL: begin
        mul_a     = 33'(le_r);
        mul_b     = (i_r == ni) ? ONE : 33'($signed(ib_rdata));
        p_nxt     = prod;
        wq_nxt    = $signed(w_rdata);
        state_nxt = S_UWR;
      end
      S_UWR: begin
        w_we    = 1'b1;
        w_waddr = waddr_of(32'(i_r), 32'(j_r));
        w_wdata = 32'(sat32(68'(wq_r) + 68'(q_sat)));
        if (i_r == ni) begin
          if ((j_r + 1'b1) == no) state_nxt = S_UDONE;
          else begin
            j_nxt     = j_r + 1'b1;
            state_nxt = S_URD;
          end
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = S_UWRD;
        end
      end
      S_UDONE: begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = KIND_DONE;
        out_index_nxt = '0;
        out_value_nxt = '0;
        out_end_nxt   = 1'b1;
        state_nxt     = S_IDLE;
      end
      // weight read
      S_RRD: begin
        w_raddr   = waddr_of(32'(row_r), 32'(col_r));
        state_nxt = S_ROUT;
      end
      S_ROUT: begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = KIND_WEIGHT;
        out_index_nxt = row_r;
        out_value_nxt = row_ok_w ? $signed(w_rdata) : '0;
        out_end_nxt   = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      hacc_r      <= '0;
      lr_r        <= LEARN_RATE_RST;
      inc_r       <= IN_COUNT_RST;
      outc_r      <= OUT_COUNT_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      hacc_r      <= hacc_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          REG_LEARN_RATE: lr_r   <= cfg_data[16:0];
          REG_IN_COUNT:   inc_r  <= cfg_data[6:0];
          REG_OUT_COUNT:  outc_r <= cfg_data[5:0];
          default:        ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt; row_r <= row_nxt; col_r <= col_nxt;
    val_r <= val_nxt; aux_r <= aux_nxt; last_r <= last_nxt;
    i_r <= i_nxt; j_r <= j_nxt; acc_r <= acc_nxt; p_r <= p_nxt;
    x_r <= x_nxt; eop_r <= eop_nxt; d_r <= d_nxt; le_r <= le_nxt; wq_r <= wq_nxt;
    idx_r <= idx_nxt;
    out_kind_r <= out_kind_nxt; out_index_r <= out_index_nxt;
    out_value_r <= out_value_nxt; out_end_r <= out_end_nxt;
  end

  assign busy             = state_r != S_IDLE;
  assign cfg_ready        = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_index        = out_index_r;
  assign out_result_value = out_value_r;
  assign out_run_end      = out_end_r;

  // a result beat only follows a working cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r != S_IDLE))
    else $error("result beat without a running command");

  // a known command always starts the sequencer
  assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_cmd <= CMD_READ) |=> busy)
    else $error("accepted command did not start");

  // row counter stays within the bias row
  assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> (i_r <= ni))
    else $error("row counter beyond bias row");

  // hidden accumulator cleared after its last term
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_HACC && last_r) |=> (hacc_r == '0))
    else $error("hidden accumulator not cleared");

endmodule
